>>> hw/rtl/gbts_pkg.sv
// ----------------------------------------------------------------------------
// gbts_pkg
// Types and constants shared by the gap buffer text store modules.
// ----------------------------------------------------------------------------
package gbts_pkg;

   localparam int CAPACITY = 4096;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int POS_W    = ADDR_W + 1;
   localparam logic [POS_W-1:0] CAP_POS = POS_W'(CAPACITY);

   typedef enum logic [2:0] {
      CMD_INSERT     = 3'd0,
      CMD_DEL_BACK   = 3'd1,
      CMD_DEL_FWD    = 3'd2,
      CMD_SET_CURSOR = 3'd3,
      CMD_READ       = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_DONE     = 2'd0,
      ST_FULL     = 2'd1,
      ST_BOUNDARY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SHIFT,
      S_EDIT,
      S_READ_WAIT,
      S_RESULT
   } state_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [7:0]        wdata;
      logic              re;
      logic [ADDR_W-1:0] raddr;
   } ram_req_type;

   typedef struct packed {
      logic [7:0]       char_out;
      logic [POS_W-1:0] text_length;
      logic [POS_W-1:0] cursor;
      status_type       status;
      logic             modified;
   } result_type;

endpackage

>>> hw/rtl/gbts_ram.sv
// ----------------------------------------------------------------------------
// gbts_ram
// Text byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gbts_ram (
   input  logic                 clock,
   input  gbts_pkg::ram_req_type ram_req,
   output logic [7:0]           rd_data_ff
);
   import gbts_pkg::*;

   logic [7:0] store_ff [CAPACITY];

   always_ff @(posedge clock) begin
      if (ram_req.we) begin
         store_ff[ram_req.waddr] <= ram_req.wdata;
      end
      if (ram_req.re) begin
         rd_data_ff <= store_ff[ram_req.raddr];
      end
   end

endmodule

>>> hw/rtl/gbts_ctrl.sv
// ----------------------------------------------------------------------------
// gbts_ctrl
// Command sequencer: gap pointers, cursor, gap shifting and edits.
// ----------------------------------------------------------------------------
module gbts_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [2:0]                  req_command,
   input  logic [gbts_pkg::POS_W-1:0]  req_position,
   input  logic [7:0]                  req_char_in,
   output logic                        res_valid,
   input  logic                        res_ready,
   output gbts_pkg::result_type        res,
   output gbts_pkg::ram_req_type       ram_req,
   input  logic [7:0]                  ram_rd_data
);
   import gbts_pkg::*;

   state_type         state_ff,     state_in;
   logic [POS_W-1:0]  gap_first_ff, gap_first_in;
   logic [POS_W-1:0]  gap_after_ff, gap_after_in;
   logic [POS_W-1:0]  cursor_ff,    cursor_in;
   logic              changed_ff,   changed_in;
   cmd_type           cmd_ff,       cmd_in;
   logic [7:0]        ch_ff,        ch_in;
   status_type        status_ff,    status_in;
   logic [7:0]        char_ff,      char_in;
   logic              wr_pend_ff,   wr_pend_in;
   logic [ADDR_W-1:0] wr_addr_ff,   wr_addr_in;

   logic [POS_W-1:0] len_cur;
   logic [POS_W-1:0] gf_dec, gf_inc, ga_dec, ga_inc;
   logic [POS_W-1:0] phys;
   logic             accept;
   logic             at_gap;

   assign len_cur  = CAP_POS - (gap_after_ff - gap_first_ff);
   assign gf_dec   = gap_first_ff - 1'b1;
   assign gf_inc   = gap_first_ff + 1'b1;
   assign ga_dec   = gap_after_ff - 1'b1;
   assign ga_inc   = gap_after_ff + 1'b1;
   assign at_gap   = (gap_first_ff == cursor_ff);
   assign phys     = (req_position < gap_first_ff) ? req_position
                   : gap_after_ff + (req_position - gap_first_ff);

   assign req_ready = (state_ff == S_IDLE) || ((state_ff == S_RESULT) && res_ready);
   assign accept    = req_valid && req_ready;
   assign res_valid = (state_ff == S_RESULT);

   assign res.char_out    = char_ff;
   assign res.text_length = len_cur;
   assign res.cursor      = cursor_ff;
   assign res.status      = status_ff;
   assign res.modified    = changed_ff;

   always_comb begin
      state_in     = state_ff;
      gap_first_in = gap_first_ff;
      gap_after_in = gap_after_ff;
      cursor_in    = cursor_ff;
      changed_in   = changed_ff;
      cmd_in       = cmd_ff;
      ch_in        = ch_ff;
      status_in    = status_ff;
      char_in      = char_ff;
      wr_pend_in   = 1'b0;
      wr_addr_in   = wr_addr_ff;
      ram_req      = '0;

      // complete the copy issued last cycle
      if (wr_pend_ff) begin
         ram_req.we    = 1'b1;
         ram_req.waddr = wr_addr_ff;
         ram_req.wdata = ram_rd_data;
      end

      unique case (state_ff)
         S_IDLE: begin
         end
         S_SHIFT: begin
            // last copy drains this cycle, edit follows with the port free
            if (at_gap) begin
               state_in = S_EDIT;
            end else if (cursor_ff < gap_first_ff) begin
               ram_req.re   = 1'b1;
               ram_req.raddr = gf_dec[ADDR_W-1:0];
               wr_pend_in   = 1'b1;
               wr_addr_in   = ga_dec[ADDR_W-1:0];
               gap_first_in = gf_dec;
               gap_after_in = ga_dec;
            end else begin
               ram_req.re   = 1'b1;
               ram_req.raddr = gap_after_ff[ADDR_W-1:0];
               wr_pend_in   = 1'b1;
               wr_addr_in   = gap_first_ff[ADDR_W-1:0];
               gap_first_in = gf_inc;
               gap_after_in = ga_inc;
            end
         end
         S_EDIT: begin
            state_in   = S_RESULT;
            changed_in = 1'b1;
            unique case (cmd_ff)
               CMD_INSERT: begin
                  ram_req.we    = 1'b1;
                  ram_req.waddr = gap_first_ff[ADDR_W-1:0];
                  ram_req.wdata = ch_ff;
                  gap_first_in  = gf_inc;
                  cursor_in     = cursor_ff + 1'b1;
               end
               CMD_DEL_BACK: begin
                  gap_first_in = gf_dec;
                  cursor_in    = cursor_ff - 1'b1;
               end
               CMD_DEL_FWD: begin
                  gap_after_in = ga_inc;
               end
               default: begin
               end
            endcase
         end
         S_READ_WAIT: begin
            char_in  = ram_rd_data;
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (accept) begin
         cmd_in    = cmd_type'(req_command);
         ch_in     = req_char_in;
         status_in = ST_DONE;
         char_in   = 8'd0;
         state_in  = S_RESULT;
         unique case (req_command)
            CMD_INSERT: begin
               if (gap_first_ff >= gap_after_ff) begin
                  status_in = ST_FULL;
               end else begin
                  state_in = at_gap ? S_EDIT : S_SHIFT;
               end
            end
            CMD_DEL_BACK: begin
               if (cursor_ff == '0) begin
                  status_in = ST_BOUNDARY;
               end else begin
                  state_in = at_gap ? S_EDIT : S_SHIFT;
               end
            end
            CMD_DEL_FWD: begin
               if (cursor_ff >= len_cur) begin
                  status_in = ST_BOUNDARY;
               end else begin
                  state_in = at_gap ? S_EDIT : S_SHIFT;
               end
            end
            CMD_SET_CURSOR: begin
               cursor_in = (req_position > len_cur) ? len_cur : req_position;
            end
            CMD_READ: begin
               if (req_position < len_cur) begin
                  ram_req.re    = 1'b1;
                  ram_req.raddr = phys[ADDR_W-1:0];
                  state_in      = S_READ_WAIT;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         gap_first_ff <= '0;
         gap_after_ff <= CAP_POS;
         cursor_ff    <= '0;
         changed_ff   <= 1'b0;
         wr_pend_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gap_first_ff <= gap_first_in;
         gap_after_ff <= gap_after_in;
         cursor_ff    <= cursor_in;
         changed_ff   <= changed_in;
         wr_pend_ff   <= wr_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      ch_ff      <= ch_in;
      status_ff  <= status_in;
      char_ff    <= char_in;
      wr_addr_ff <= wr_addr_in;
   end

endmodule

>>> hw/rtl/gap_buffer_text_store.sv
// Set cursor, ignored or rejected commands and reads past the end go straight
// to the result state; a read passes the read wait state, an edit at the
// cursor the edit state, and an edit elsewhere first moves the gap one byte
// per shift step. One set cursor or rejected edit per cycle while the output
// is not stalled; a read or edit holds off new requests until its result is out.
// Reset empties the text and zeroes cursor and modified flag, not the store.
// ----------------------------------------------------------------------------
// gap_buffer_text_store
// Fixed capacity gap buffer text store with cursor and output register.
// ----------------------------------------------------------------------------
module gap_buffer_text_store (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [2:0]                  req_command,
   input  logic [gbts_pkg::POS_W-1:0]  req_position,
   input  logic [7:0]                  req_char_in,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [7:0]                  rsp_char_out,
   output logic [gbts_pkg::POS_W-1:0]  rsp_text_length,
   output logic [gbts_pkg::POS_W-1:0]  rsp_cursor,
   output logic [1:0]                  rsp_status,
   output logic                        rsp_modified
);
   import gbts_pkg::*;

   ram_req_type ram_req;
   logic [7:0]  ram_rd_data;
   result_type  res;
   logic        res_valid;
   logic        res_ready;

   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_data_ff,  rsp_data_in;

   gbts_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_command  (req_command),
      .req_position (req_position),
      .req_char_in  (req_char_in),
      .res_valid    (res_valid),
      .res_ready    (res_ready),
      .res          (res),
      .ram_req      (ram_req),
      .ram_rd_data  (ram_rd_data)
   );

   gbts_ram u_ram (
      .clock      (clock),
      .ram_req    (ram_req),
      .rd_data_ff (ram_rd_data)
   );

   // take a new result when the register is empty or being drained
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_data_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_char_out    = rsp_data_ff.char_out;
   assign rsp_text_length = rsp_data_ff.text_length;
   assign rsp_cursor      = rsp_data_ff.cursor;
   assign rsp_status      = rsp_data_ff.status;
   assign rsp_modified    = rsp_data_ff.modified;

   a_len_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_text_length <= CAP_POS) && (rsp_cursor <= rsp_text_length))
      else $error("cursor or length out of range");

   a_full_only_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL) |-> rsp_text_length == CAP_POS)
      else $error("full status with room left");

   a_boundary_at_edge: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_BOUNDARY)
         |-> (rsp_cursor == '0) || (rsp_cursor == rsp_text_length))
      else $error("boundary status away from a boundary");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      res_valid && !res_ready |=> res_valid && $stable(res))
      else $error("pending result lost while output register busy");

endmodule

>>> dv/gap_buffer_text_store_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gap_buffer_text_store_test
// Self-checking bench for the gap buffer text store. Directed requests cover
// the empty-text boundary cases, then random edit, cursor, read and undefined
// command traffic runs on a short text. A scoreboard predicts every response
// from a copy of the text and cursor.
// ----------------------------------------------------------------------------
module gap_buffer_text_store_test;
   import gbts_pkg::*;

   localparam int unsigned MAIN_REQUESTS = 1830;
   localparam int unsigned DRAIN_LIMIT   = 20000;
   localparam int unsigned IDLE_PCT      = 11;

   class text_scoreboard;
      logic [7:0]  text_q[$];
      int unsigned cursor_at;
      logic        changed;
      result_type  expected_q[$];
      int unsigned fail_count;
      int unsigned rsp_index;

      function new();
         cursor_at  = 0;
         changed    = 1'b0;
         fail_count = 0;
         rsp_index  = 0;
      endfunction

      function int unsigned text_size();
         return text_q.size();
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      task log_mismatch(string msg);
         $display("mismatch at response %0d: %s", rsp_index, msg);
         fail_count++;
      endtask

      // Apply one accepted request to the text copy and queue its response.
      function void note_request(logic [2:0] cmd, logic [POS_W-1:0] pos, logic [7:0] ch);
         result_type r;
         r          = '0;
         r.status   = ST_DONE;
         case (cmd)
            CMD_INSERT: begin
               if (text_q.size() >= CAPACITY) begin
                  r.status = ST_FULL;
               end else begin
                  text_q.insert(cursor_at, ch);
                  cursor_at++;
                  changed = 1'b1;
               end
            end
            CMD_DEL_BACK: begin
               if (cursor_at == 0) begin
                  r.status = ST_BOUNDARY;
               end else begin
                  text_q.delete(cursor_at - 1);
                  cursor_at--;
                  changed = 1'b1;
               end
            end
            CMD_DEL_FWD: begin
               if (cursor_at >= text_q.size()) begin
                  r.status = ST_BOUNDARY;
               end else begin
                  text_q.delete(cursor_at);
                  changed = 1'b1;
               end
            end
            CMD_SET_CURSOR: begin
               cursor_at = (pos > text_q.size()) ? text_q.size() : pos;
            end
            CMD_READ: begin
               if (pos < text_q.size()) r.char_out = text_q[pos];
            end
            default: begin
            end
         endcase
         r.text_length = POS_W'(text_q.size());
         r.cursor      = POS_W'(cursor_at);
         r.modified    = changed;
         expected_q.push_back(r);
      endfunction

      task check_response(logic [7:0] char_out, logic [POS_W-1:0] length,
                          logic [POS_W-1:0] cursor, logic [1:0] status, logic modified);
         result_type want;
         if (expected_q.size() == 0) begin
            log_mismatch($sformatf("response with nothing outstanding (len %0d cursor %0d)",
                                   length, cursor));
         end else begin
            want = expected_q.pop_front();
            if (char_out !== want.char_out)
               log_mismatch($sformatf("char_out got %02h want %02h", char_out, want.char_out));
            if (length !== want.text_length)
               log_mismatch($sformatf("text_length got %0d want %0d", length,
                                      want.text_length));
            if (cursor !== want.cursor)
               log_mismatch($sformatf("cursor got %0d want %0d", cursor, want.cursor));
            if (status !== want.status)
               log_mismatch($sformatf("status got %0d want %0d", status, want.status));
            if (modified !== want.modified)
               log_mismatch($sformatf("modified got %0b want %0b", modified, want.modified));
         end
         rsp_index++;
      endtask
   endclass

   logic              clock        = 1'b0;
   logic              reset        = 1'b1;
   logic              req_valid    = 1'b0;
   logic              req_ready;
   logic [2:0]        req_command  = CMD_INSERT;
   logic [POS_W-1:0]  req_position = '0;
   logic [7:0]        req_char_in  = '0;
   logic              rsp_valid;
   logic              rsp_ready    = 1'b0;
   logic [7:0]        rsp_char_out;
   logic [POS_W-1:0]  rsp_text_length;
   logic [POS_W-1:0]  rsp_cursor;
   logic [1:0]        rsp_status;
   logic              rsp_modified;

   logic              quiet        = 1'b0;
   text_scoreboard    sb           = new();

   gap_buffer_text_store u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_position    (req_position),
      .req_char_in     (req_char_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_char_out    (rsp_char_out),
      .rsp_text_length (rsp_text_length),
      .rsp_cursor      (rsp_cursor),
      .rsp_status      (rsp_status),
      .rsp_modified    (rsp_modified)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         sb.note_request(req_command, req_position, req_char_in);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_char_out, rsp_text_length, rsp_cursor, rsp_status,
                           rsp_modified);
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_request(input logic [2:0] cmd, input logic [POS_W-1:0] pos,
                               input logic [7:0] ch);
      while (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_command  <= cmd;
      req_position <= pos;
      req_char_in  <= ch;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic wait_drain();
      int unsigned waited;
      waited = 0;
      req_valid <= 1'b0;
      while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      if (sb.pending() != 0)
         sb.log_mismatch($sformatf("%0d responses still outstanding", sb.pending()));
   endtask

   function automatic logic [POS_W-1:0] pick_position(int unsigned len);
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 70) return POS_W'($urandom_range(len));
      else if (roll < 85) return POS_W'(len + $urandom_range(3));
      else if (roll < 95) return POS_W'($urandom);
      else return roll[0] ? POS_W'(len) : '0;
   endfunction

   // Weighted mix of all commands; jump_w sets how often the cursor moves away.
   task automatic send_random(input int unsigned ins_w, input int unsigned jump_w);
      int unsigned      roll;
      logic [POS_W-1:0] pos;
      roll = $urandom_range(99);
      pos  = pick_position(sb.text_size());
      if (roll < ins_w)
         send_request(CMD_INSERT, pos, 8'($urandom));
      else if (roll < ins_w + 12)
         send_request(CMD_DEL_BACK, pos, 8'($urandom));
      else if (roll < ins_w + 24)
         send_request(CMD_DEL_FWD, pos, 8'($urandom));
      else if (roll < ins_w + 24 + jump_w)
         send_request(CMD_SET_CURSOR, pos, 8'($urandom));
      else if (roll < 97)
         send_request(CMD_READ, pos, 8'($urandom));
      else
         send_request(CMD_READ + 3'($urandom_range(3, 1)), pos, 8'($urandom));
   endtask

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Empty text: boundaries, clamping and read past the end.
      send_request(CMD_READ, '0, 8'h00);
      send_request(CMD_DEL_BACK, '0, 8'h00);
      send_request(CMD_DEL_FWD, '0, 8'h00);
      send_request(CMD_SET_CURSOR, CAP_POS, 8'h00);
      send_request(CMD_INSERT, '0, 8'h00);
      send_request(CMD_INSERT, '0, 8'hFF);
      send_request(CMD_INSERT, '0, 8'h5A);
      send_request(CMD_SET_CURSOR, POS_W'(1), 8'h00);
      send_request(CMD_INSERT, '1, 8'hA5);
      send_request(CMD_SET_CURSOR, '0, 8'h00);
      send_request(CMD_DEL_FWD, '0, 8'h00);
      send_request(CMD_READ, '0, 8'h00);
      send_request(CMD_READ, POS_W'(2), 8'h00);
      send_request(CMD_READ, POS_W'(3), 8'h00);
      send_request(CMD_READ, '1, 8'h00);
      send_request(CMD_SET_CURSOR, '1, 8'h00);
      send_request(CMD_DEL_BACK, '0, 8'h00);
      send_request(CMD_INSERT, '1, 8'h80);
      for (int k = 1; k <= 3; k++)
         send_request(CMD_READ + 3'(k), '1, 8'hFF);
      send_request(CMD_READ, CAP_POS, 8'h00);
      wait_drain();

      for (int unsigned i = 0; i < MAIN_REQUESTS; i++) begin
         quiet = (i >= 500 && i < 800);
         send_random(35, 12);
      end
      quiet = 1'b0;

      wait_drain();
      repeat (10) @(negedge clock);
      if (sb.pending() != 0)
         sb.log_mismatch("responses left outstanding at the end");
      if (sb.fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #200_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/gbts_pkg.sv
hw/rtl/gbts_ram.sv
hw/rtl/gbts_ctrl.sv
hw/rtl/gap_buffer_text_store.sv
dv/gap_buffer_text_store_test.sv
